// ===== design/small_matrix_inverse_macros.svh =====
// ---------------------------------------------------------------------------
// Small matrix inverse assertion macros
// Clocked assertion shorthands on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef SMALL_MATRIX_INVERSE_MACROS_SVH
`define SMALL_MATRIX_INVERSE_MACROS_SVH

// same-cycle implication
`define SMI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SMI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/smi_pkg.sv =====
// ---------------------------------------------------------------------------
// Small matrix inverse package
// Widths, payload types, codes and cofactor index table.
// ---------------------------------------------------------------------------
package smi_pkg;

  localparam int ENTRY_BITS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int IN_BITS    = 16;
  localparam int RES_BITS   = 32;
  localparam int NLANE      = 9;

  localparam int QB   = RES_BITS - 1;
  localparam int AMW  = 2 * ENTRY_BITS;
  localparam int CFW  = 2 * ENTRY_BITS + 1;
  localparam int TPW  = CFW + ENTRY_BITS;
  localparam int DSW  = 3 * ENTRY_BITS + 3;
  localparam int DW   = 3 * ENTRY_BITS;
  localparam int NW   = AMW + FRAC_BITS;
  localparam int CW   = (NW > DW) ? NW : DW;
  localparam int BPS  = 2;
  localparam int DSTG = (QB + BPS - 1) / BPS;

  localparam logic [1:0] SIZE_1 = 2'd1;
  localparam logic [1:0] SIZE_2 = 2'd2;
  localparam logic [1:0] SIZE_3 = 2'd3;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_SINGULAR = 1'b1;

  typedef logic signed [ENTRY_BITS-1:0] ent_t;
  typedef logic signed [2*ENTRY_BITS-1:0] prod_t;
  typedef logic signed [CFW-1:0] cf_t;
  typedef logic signed [TPW-1:0] tp_t;
  typedef logic signed [DSW-1:0] dt_t;
  typedef logic signed [RES_BITS-1:0] res_t;

  typedef struct packed {
    logic [1:0]                mat_size;
    logic signed [IN_BITS-1:0] a00;
    logic signed [IN_BITS-1:0] a01;
    logic signed [IN_BITS-1:0] a02;
    logic signed [IN_BITS-1:0] a10;
    logic signed [IN_BITS-1:0] a11;
    logic signed [IN_BITS-1:0] a12;
    logic signed [IN_BITS-1:0] a20;
    logic signed [IN_BITS-1:0] a21;
    logic signed [IN_BITS-1:0] a22;
  } in_t;

  typedef struct packed {
    logic status;
    res_t r00;
    res_t r01;
    res_t r02;
    res_t r10;
    res_t r11;
    res_t r12;
    res_t r20;
    res_t r21;
    res_t r22;
  } out_t;

  // cofactor k = p(idx0)*p(idx1) - p(idx2)*p(idx3), entries row-major
  localparam logic [3:0] CF_IDX [NLANE][4] = '{
    '{4'd4, 4'd8, 4'd5, 4'd7},
    '{4'd5, 4'd6, 4'd3, 4'd8},
    '{4'd3, 4'd7, 4'd4, 4'd6},
    '{4'd2, 4'd7, 4'd1, 4'd8},
    '{4'd0, 4'd8, 4'd2, 4'd6},
    '{4'd1, 4'd6, 4'd0, 4'd7},
    '{4'd1, 4'd5, 4'd2, 4'd4},
    '{4'd2, 4'd3, 4'd0, 4'd5},
    '{4'd0, 4'd4, 4'd1, 4'd3}
  };

endpackage

// ===== design/smi_divider.sv =====
// ---------------------------------------------------------------------------
// Small matrix inverse divider
// Nine-lane pipelined restoring divider with shared determinant, Q format
// scaling, sign restore and saturation; two quotient bits per stage.
// ---------------------------------------------------------------------------
module smi_divider (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_v,
  input  smi_pkg::cf_t     adj [smi_pkg::NLANE],
  input  smi_pkg::dt_t     det,
  output logic             out_v,
  output logic             sing,
  output smi_pkg::res_t    res [smi_pkg::NLANE]
);
  import smi_pkg::*;

  typedef struct packed {
    logic [DW-1:0] rem;
    logic [QB-1:0] lo;
    logic [QB-1:0] q;
    logic          neg;
    logic          sat;
  } lane_t;

  typedef struct packed {
    lane_t [NLANE-1:0] ln;
    logic [DW-1:0]     d;
    logic              sing;
  } item_t;

  function automatic item_t div_step(item_t x, int unsigned k);
    item_t         y;
    logic [DW:0]   r2;
    y = x;
    for (int l = 0; l < NLANE; l++) begin
      for (int s = 0; s < BPS; s++) begin
        if (BPS * k + s < QB) begin
          r2 = {y.ln[l].rem, y.ln[l].lo[QB-1]};
          y.ln[l].lo = y.ln[l].lo << 1;
          if (r2 >= {1'b0, y.d}) begin
            y.ln[l].rem = DW'(r2 - {1'b0, y.d});
            y.ln[l].q   = {y.ln[l].q[QB-2:0], 1'b1};
          end else begin
            y.ln[l].rem = r2[DW-1:0];
            y.ln[l].q   = {y.ln[l].q[QB-2:0], 1'b0};
          end
        end
      end
    end
    return y;
  endfunction

  logic [NW-1:0] a_n_r [NLANE];
  logic [NW-1:0] a_n_nxt [NLANE];
  logic          a_neg_r [NLANE];
  logic          a_neg_nxt [NLANE];
  logic [DW-1:0] a_d_r, a_d_nxt;
  logic          a_sing_r, a_sing_nxt;
  logic          a_v_r;

  item_t         st_r   [DSTG+1];
  item_t         st_nxt [DSTG+1];
  logic [DSTG:0] st_v_r;

  res_t          f_res_r   [NLANE];
  res_t          f_res_nxt [NLANE];
  logic          f_sing_r, f_sing_nxt;
  logic          f_v_r;

  always_comb begin
    logic [CFW-1:0] m;
    logic [DSW-1:0] dm;
    dm         = det[DSW-1] ? DSW'(-det) : DSW'(det);
    a_d_nxt    = dm[DW-1:0];
    a_sing_nxt = (det == '0);
    for (int l = 0; l < NLANE; l++) begin
      m            = adj[l][CFW-1] ? CFW'(-adj[l]) : CFW'(adj[l]);
      a_n_nxt[l]   = NW'(m[AMW-1:0]) << FRAC_BITS;
      a_neg_nxt[l] = adj[l][CFW-1] ^ det[DSW-1];
    end
  end

  always_comb begin
    logic [NW-1:0] hi;
    st_nxt[0].d    = a_d_r;
    st_nxt[0].sing = a_sing_r;
    for (int l = 0; l < NLANE; l++) begin
      hi                   = a_n_r[l] >> QB;
      st_nxt[0].ln[l].rem  = DW'(hi);
      st_nxt[0].ln[l].lo   = QB'(a_n_r[l]);
      st_nxt[0].ln[l].q    = '0;
      st_nxt[0].ln[l].neg  = a_neg_r[l];
      st_nxt[0].ln[l].sat  = (CW'(hi) >= CW'(a_d_r));
    end
  end

  for (genvar k = 0; k < DSTG; k++) begin : g_step
    always_comb begin
      st_nxt[k+1] = div_step(st_r[k], k);
    end
  end

  always_comb begin
    lane_t ln;
    f_sing_nxt = st_r[DSTG].sing;
    for (int l = 0; l < NLANE; l++) begin
      ln = st_r[DSTG].ln[l];
      if (st_r[DSTG].sing) begin
        f_res_nxt[l] = '0;
      end else if (ln.sat) begin
        f_res_nxt[l] = ln.neg ? {1'b1, {QB{1'b0}}} : {1'b0, {QB{1'b1}}};
      end else if (ln.neg) begin
        f_res_nxt[l] = -$signed({1'b0, ln.q});
      end else begin
        f_res_nxt[l] = $signed({1'b0, ln.q});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r  <= 1'b0;
      st_v_r <= '0;
      f_v_r  <= 1'b0;
    end else if (en) begin
      a_v_r  <= in_v;
      st_v_r <= {st_v_r[DSTG-1:0], a_v_r};
      f_v_r  <= st_v_r[DSTG];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_n_r    <= a_n_nxt;
      a_neg_r  <= a_neg_nxt;
      a_d_r    <= a_d_nxt;
      a_sing_r <= a_sing_nxt;
      for (int k = 0; k <= DSTG; k++) begin
        st_r[k] <= st_nxt[k];
      end
      f_res_r  <= f_res_nxt;
      f_sing_r <= f_sing_nxt;
    end
  end

  assign out_v = f_v_r;
  assign sing  = f_sing_r;
  assign res   = f_res_r;

endmodule

// ===== design/small_matrix_inverse.sv =====
// ---------------------------------------------------------------------------
// Small matrix inverse
// Inverse of a 1x1, 2x2 or 3x3 signed integer matrix in saturating Q16.16.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready/in_data carries one matrix per
//   transaction: mat_size and nine row-major entries, unused ones ignored.
//   Output channel out_valid/out_ready/out_data returns one result per
//   matrix, in order: status (1 for zero determinant) and nine entries,
//   zero outside the active size and zero when singular.
//   The pipeline is 24 register stages deep, 16 of them the nine-lane
//   restoring divider at two quotient bits each. out_valid rises once the
//   matrix has passed all of them. One matrix is taken every cycle while
//   in_ready is high.
//   The whole pipeline advances together; a one-entry skid register at the
//   output takes the head result when the receiver stalls, and in_ready
//   falls only while that skid register is full.
//   Reset (rst_n low, synchronous) empties the pipeline and the skid
//   register; no clearing pass is needed, the data registers are not reset.
// ---------------------------------------------------------------------------
module small_matrix_inverse (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  smi_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output smi_pkg::out_t  out_data
);
  import smi_pkg::*;
  `include "small_matrix_inverse_macros.svh"

  function automatic ent_t take_entry(logic [IN_BITS-1:0] f);
    logic [ENTRY_BITS+IN_BITS-1:0] raw;
    raw = (ENTRY_BITS + IN_BITS)'(f);
    return raw[ENTRY_BITS-1:0];
  endfunction

  logic       en;
  logic [4:0] v_r;

  logic [1:0] s0_size_r;
  ent_t       s0_a_r   [NLANE];
  ent_t       s0_a_nxt [NLANE];

  logic [1:0] s1_size_r;
  ent_t       s1_a_r   [NLANE];
  prod_t      s1_p_r   [NLANE][2];
  prod_t      s1_p_nxt [NLANE][2];

  logic [1:0] s2_size_r;
  cf_t        s2_adj_r   [NLANE];
  cf_t        s2_adj_nxt [NLANE];
  cf_t        s2_c0_r    [3];
  ent_t       s2_a0_r    [3];
  cf_t        s2_c22_r;

  logic [1:0] s3_size_r;
  cf_t        s3_adj_r  [NLANE];
  tp_t        s3_t_r    [3];
  tp_t        s3_t_nxt  [3];
  cf_t        s3_c22_r;
  ent_t       s3_a00_r;

  cf_t        s4_adj_r [NLANE];
  dt_t        s4_det_r, s4_det_nxt;

  logic       p_v;
  logic       p_sing;
  res_t       p_res [NLANE];
  out_t       p_data;

  logic       skid_v_r;
  out_t       skid_r;

  assign en       = !skid_v_r;
  assign in_ready = en;

  always_comb begin
    s0_a_nxt[0] = take_entry(in_data.a00);
    s0_a_nxt[1] = take_entry(in_data.a01);
    s0_a_nxt[2] = take_entry(in_data.a02);
    s0_a_nxt[3] = take_entry(in_data.a10);
    s0_a_nxt[4] = take_entry(in_data.a11);
    s0_a_nxt[5] = take_entry(in_data.a12);
    s0_a_nxt[6] = take_entry(in_data.a20);
    s0_a_nxt[7] = take_entry(in_data.a21);
    s0_a_nxt[8] = take_entry(in_data.a22);
  end

  always_comb begin
    for (int k = 0; k < NLANE; k++) begin
      s1_p_nxt[k][0] = prod_t'(s0_a_r[CF_IDX[k][0]]) * prod_t'(s0_a_r[CF_IDX[k][1]]);
      s1_p_nxt[k][1] = prod_t'(s0_a_r[CF_IDX[k][2]]) * prod_t'(s0_a_r[CF_IDX[k][3]]);
    end
  end

  always_comb begin
    cf_t c [NLANE];
    for (int k = 0; k < NLANE; k++) begin
      c[k]          = cf_t'(s1_p_r[k][0]) - cf_t'(s1_p_r[k][1]);
      s2_adj_nxt[k] = '0;
    end
    case (s1_size_r)
      SIZE_3: begin
        for (int i = 0; i < 3; i++) begin
          for (int j = 0; j < 3; j++) begin
            s2_adj_nxt[i*3+j] = c[j*3+i];
          end
        end
      end
      SIZE_2: begin
        s2_adj_nxt[0] = cf_t'(s1_a_r[4]);
        s2_adj_nxt[1] = -cf_t'(s1_a_r[1]);
        s2_adj_nxt[3] = -cf_t'(s1_a_r[3]);
        s2_adj_nxt[4] = cf_t'(s1_a_r[0]);
      end
      SIZE_1: begin
        s2_adj_nxt[0] = cf_t'(1);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      s3_t_nxt[j] = tp_t'(s2_c0_r[j]) * tp_t'(s2_a0_r[j]);
    end
  end

  always_comb begin
    case (s3_size_r)
      SIZE_3:  s4_det_nxt = dt_t'(s3_t_r[0]) + dt_t'(s3_t_r[1]) + dt_t'(s3_t_r[2]);
      SIZE_2:  s4_det_nxt = dt_t'(s3_c22_r);
      SIZE_1:  s4_det_nxt = dt_t'(s3_a00_r);
      default: s4_det_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_size_r <= in_data.mat_size;
      s0_a_r    <= s0_a_nxt;
      s1_size_r <= s0_size_r;
      s1_a_r    <= s0_a_r;
      s1_p_r    <= s1_p_nxt;
      s2_size_r <= s1_size_r;
      s2_adj_r  <= s2_adj_nxt;
      for (int j = 0; j < 3; j++) begin
        s2_c0_r[j] <= cf_t'(s1_p_r[j][0]) - cf_t'(s1_p_r[j][1]);
        s2_a0_r[j] <= s1_a_r[j];
      end
      s2_c22_r  <= cf_t'(s1_p_r[8][0]) - cf_t'(s1_p_r[8][1]);
      s3_size_r <= s2_size_r;
      s3_adj_r  <= s2_adj_r;
      s3_t_r    <= s3_t_nxt;
      s3_c22_r  <= s2_c22_r;
      s3_a00_r  <= s2_a0_r[0];
      s4_adj_r  <= s3_adj_r;
      s4_det_r  <= s4_det_nxt;
    end
  end

  smi_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_v  (v_r[4]),
    .adj   (s4_adj_r),
    .det   (s4_det_r),
    .out_v (p_v),
    .sing  (p_sing),
    .res   (p_res)
  );

  always_comb begin
    p_data.status = p_sing ? STATUS_SINGULAR : STATUS_OK;
    p_data.r00    = p_res[0];
    p_data.r01    = p_res[1];
    p_data.r02    = p_res[2];
    p_data.r10    = p_res[3];
    p_data.r11    = p_res[4];
    p_data.r12    = p_res[5];
    p_data.r20    = p_res[6];
    p_data.r21    = p_res[7];
    p_data.r22    = p_res[8];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_ready) begin
        skid_v_r <= 1'b0;
      end
    end else if (p_v && !out_ready) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_v_r) begin
      skid_r <= p_data;
    end
  end

  assign out_valid = skid_v_r || p_v;
  assign out_data  = skid_v_r ? skid_r : p_data;

  `SMI_ASSERT_NXT(a_skid_hold, skid_v_r && !out_ready, $stable(out_data), "skid result moved")
  `SMI_ASSERT_IMP(a_skid_fill, $rose(skid_v_r), $past(p_v && !out_ready), "skid filled without stall")
  `SMI_ASSERT_IMP(a_singular_zero, out_valid && out_data.status == STATUS_SINGULAR, out_data.r00 == '0 && out_data.r11 == '0 && out_data.r22 == '0 && out_data.r01 == '0 && out_data.r10 == '0, "singular result not zero")

endmodule
